// File: hdl/smax_pkg.sv
// Shared constants, command/status types and the exponent table for the softmax head.
`timescale 1ns / 1ps
package smax_pkg;

    localparam int NUM_CLASSES_DEF = 5;
    localparam int LOGIT_W         = 16;
    localparam int CLASS_W         = 3;
    localparam int CONF_W          = 16;
    localparam int FRAC_W          = 17;   // 1.0 = 65536
    localparam int T_W             = 33;   // difference times log2(e)
    localparam int SHIFT_W         = 9;    // integer part of t
    localparam int PROD_W          = 24;
    localparam int QUO_W           = 17;
    localparam int DIV_CNT_W       = 5;

    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUO_W - 1);
    localparam logic [SHIFT_W-1:0] SHIFT_LIMIT = SHIFT_W'(17);

    typedef struct packed {
        logic accept;
        logic sum_clr;
        logic rd_en;
        logic div_init;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic last_slot;
        logic pipe_empty;
        logic out_free;
    } t_status;

    // 2^(-k/16) scaled by 65536, k = 0..16
    function automatic logic [FRAC_W-1:0] pow2_frac(input logic [4:0] k);
        logic [FRAC_W-1:0] v;
        unique case (k)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            5'd16:   v = 17'd32768;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/softmax_argmax_classifier_head_unit.sv
// Top level of the softmax/argmax classifier head.
//
// Input channel: one signed Q8.8 class logit per word on i_logit, qualified by
// i_in_valid, held off by o_in_stall. NUM_CLASSES words, in class order, make
// one vector. Output channel: one word per vector on o_class_index (argmax,
// lowest index on ties) and o_confidence (softmax probability, Q0.16,
// saturated at 65535), qualified by o_out_valid, held off by i_out_stall.
// Logits load one per cycle while o_in_stall is low. After the last one the
// store is walked through a three-stage exponent pipeline (one read per
// cycle, then the pipeline drains), then a restoring divider forms 2^32/sum
// at one bit per cycle, and the result is loaded into the output register.
// A new vector can start only after that load, so the logit load and the
// bit-serial divider both bound the vector rate.
// Input is stalled from the last logit until the result is loaded into the
// output register. If the receiver stalls, the result waits there while the
// next vector loads; the block stalls again only if that next result is
// ready before the previous word is taken.
// Reset (synchronous, active low) clears the vector count, sequencer state
// and output valid; stored logits are not cleared.
`timescale 1ns / 1ps
module softmax_argmax_classifier_head_unit #(
    parameter int NUM_CLASSES = smax_pkg::NUM_CLASSES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [smax_pkg::LOGIT_W-1:0] i_logit,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [smax_pkg::CLASS_W-1:0]        o_class_index,
    output logic [smax_pkg::CONF_W-1:0]         o_confidence
);
    import smax_pkg::*;

    t_cmd                           cmd;
    t_status                        status;
    logic [$clog2(NUM_CLASSES)-1:0] rd_addr;

    smax_ctrl #(
        .NUM_CLASSES(NUM_CLASSES)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_status  (status),
        .o_cmd     (cmd),
        .o_rd_addr (rd_addr),
        .o_in_stall(o_in_stall)
    );

    smax_dp #(
        .NUM_CLASSES(NUM_CLASSES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_rd_addr    (rd_addr),
        .i_logit      (i_logit),
        .i_out_stall  (i_out_stall),
        .o_status     (status),
        .o_out_valid  (o_out_valid),
        .o_class_index(o_class_index),
        .o_confidence (o_confidence)
    );

endmodule

// File: hdl/smax_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module smax_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 5
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/smax_ctrl.sv
// Sequencer for load, exponent walk, division and result handoff.
`timescale 1ns / 1ps
module smax_ctrl #(
    parameter int NUM_CLASSES = smax_pkg::NUM_CLASSES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  smax_pkg::t_status              i_status,
    output smax_pkg::t_cmd                 o_cmd,
    output logic [$clog2(NUM_CLASSES)-1:0] o_rd_addr,
    output logic                           o_in_stall
);
    import smax_pkg::*;

    localparam int IDX_W = $clog2(NUM_CLASSES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_CLASSES - 1);

    typedef enum logic [4:0] {
        S_LOAD  = 5'b00001,
        S_WALK  = 5'b00010,
        S_DRAIN = 5'b00100,
        S_DIV   = 5'b01000,
        S_PUT   = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    logic [IDX_W-1:0]     r_walk, n_walk;
    logic [DIV_CNT_W-1:0] r_div, n_div;
    t_cmd                 cmd;

    always_comb begin
        n_state = r_state;
        n_walk  = r_walk;
        n_div   = r_div;
        cmd     = '0;
        unique case (r_state)
            S_LOAD: begin
                cmd.accept = i_in_valid;
                if (i_in_valid && i_status.last_slot) begin
                    cmd.sum_clr = 1'b1;
                    n_walk      = '0;
                    n_state     = S_WALK;
                end
            end
            S_WALK: begin
                cmd.rd_en = 1'b1;
                n_walk    = r_walk + 1'b1;
                if (r_walk == IDX_LAST) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_status.pipe_empty) begin
                    cmd.div_init = 1'b1;
                    n_div        = '0;
                    n_state      = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                n_div        = r_div + 1'b1;
                if (r_div == DIV_LAST) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                // hold until the output register can take the word
                if (i_status.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_walk  <= '0;
            r_div   <= '0;
        end else begin
            r_state <= n_state;
            r_walk  <= n_walk;
            r_div   <= n_div;
        end
    end

    assign o_cmd      = cmd;
    assign o_rd_addr  = r_walk;
    assign o_in_stall = (r_state != S_LOAD);

endmodule

// File: hdl/smax_dp.sv
// Datapath: logit store, running argmax, exponent pipeline, sum, divider, output register.
`timescale 1ns / 1ps
module smax_dp #(
    parameter int NUM_CLASSES = smax_pkg::NUM_CLASSES_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  smax_pkg::t_cmd                         i_cmd,
    input  logic [$clog2(NUM_CLASSES)-1:0]         i_rd_addr,
    input  logic signed [smax_pkg::LOGIT_W-1:0]    i_logit,
    input  logic                                   i_out_stall,
    output smax_pkg::t_status                      o_status,
    output logic                                   o_out_valid,
    output logic [smax_pkg::CLASS_W-1:0]           o_class_index,
    output logic [smax_pkg::CONF_W-1:0]            o_confidence
);
    import smax_pkg::*;

    localparam int IDX_W = $clog2(NUM_CLASSES);
    localparam int SUM_W = FRAC_W + $clog2(NUM_CLASSES);
    localparam int REM_W = SUM_W + 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_CLASSES - 1);
    // 2^32 / sum: quotient bits above 16 are zero, so start from 2^15
    localparam logic [REM_W-1:0] REM_INIT = REM_W'(32768);

    // load side
    logic [IDX_W-1:0]          r_count;
    logic signed [LOGIT_W-1:0] r_best;
    logic [IDX_W-1:0]          r_best_idx;
    logic                      last_slot;

    assign last_slot = (r_count == IDX_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_best     <= '0;
            r_best_idx <= '0;
        end else if (i_cmd.accept) begin
            r_count <= last_slot ? '0 : r_count + 1'b1;
            if ((r_count == '0) || (i_logit > r_best)) begin
                r_best     <= i_logit;
                r_best_idx <= r_count;
            end
        end
    end

    logic [LOGIT_W-1:0] ram_rdata;

    smax_ram #(
        .WIDTH(LOGIT_W),
        .DEPTH(NUM_CLASSES)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (i_cmd.accept),
        .i_waddr(r_count),
        .i_wdata(i_logit),
        .i_re   (i_cmd.rd_en),
        .i_raddr(i_rd_addr),
        .o_rdata(ram_rdata)
    );

    // exponent pipeline valids
    logic r_v_dout, r_v_t, r_v_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_dout <= 1'b0;
            r_v_t    <= 1'b0;
            r_v_prod <= 1'b0;
        end else begin
            r_v_dout <= i_cmd.rd_en;
            r_v_t    <= r_v_dout;
            r_v_prod <= r_v_t;
        end
    end

    // stage 1: difference times log2(e)
    logic signed [LOGIT_W:0] diff;
    logic [T_W-1:0]          r_t;

    assign diff = {r_best[LOGIT_W-1], r_best} - {ram_rdata[LOGIT_W-1], ram_rdata};

    always_ff @(posedge i_clk) begin
        if (r_v_dout) begin
            r_t <= T_W'(diff[LOGIT_W-1:0]) * T_W'(LOG2E_Q16);
        end
    end

    // stage 2: table lookup and interpolation product
    logic [15:0]        frac;
    logic [4:0]         tidx;
    logic [FRAC_W-1:0]  t_hi, t_lo, t_delta;
    logic [PROD_W-1:0]  r_prod;
    logic [FRAC_W-1:0]  r_hi;
    logic [SHIFT_W-1:0] r_n;

    assign frac    = r_t[23:8];
    assign tidx    = {1'b0, frac[15:12]};
    assign t_hi    = pow2_frac(tidx);
    assign t_lo    = pow2_frac(tidx + 5'd1);
    assign t_delta = t_hi - t_lo;

    always_ff @(posedge i_clk) begin
        if (r_v_t) begin
            r_prod <= PROD_W'(t_delta[11:0]) * PROD_W'(frac[11:0]);
            r_hi   <= t_hi;
            r_n    <= r_t[T_W-1:24];
        end
    end

    // stage 3: shift and accumulate
    logic [FRAC_W-1:0] interp, term;
    logic [SUM_W-1:0]  r_sum;

    assign interp = r_hi - FRAC_W'(r_prod[PROD_W-1:12]);
    assign term   = (r_n >= SHIFT_LIMIT) ? '0 : (interp >> r_n[4:0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_clr) begin
            r_sum <= '0;
        end else if (r_v_prod) begin
            r_sum <= r_sum + SUM_W'(term);
        end
    end

    // restoring divider, one quotient bit per cycle
    logic [REM_W-1:0] r_rem, rem_sh;
    logic [QUO_W-1:0] r_quo;
    logic             q_bit;

    assign rem_sh = {r_rem[REM_W-2:0], 1'b0};
    assign q_bit  = (rem_sh >= REM_W'(r_sum));

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem <= REM_INIT;
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= q_bit ? (rem_sh - REM_W'(r_sum)) : rem_sh;
            r_quo <= {r_quo[QUO_W-2:0], q_bit};
        end
    end

    // output register
    logic                    r_out_valid;
    logic [CLASS_W-1:0]      r_class_index;
    logic [CONF_W-1:0]       r_confidence;
    logic [IDX_W+CLASS_W-1:0] idx_ext;

    assign idx_ext = {{CLASS_W{1'b0}}, r_best_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_class_index <= idx_ext[CLASS_W-1:0];
            r_confidence  <= r_quo[QUO_W-1] ? {CONF_W{1'b1}} : r_quo[CONF_W-1:0];
        end
    end

    assign o_status.last_slot  = last_slot;
    assign o_status.pipe_empty = !(r_v_dout || r_v_t || r_v_prod);
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid   = r_out_valid;
    assign o_class_index = r_class_index;
    assign o_confidence  = r_confidence;

endmodule
